// ----- src/sic_pkg.sv -----
// shared types and constants for the segment intersection core
// no dependencies; imported by every module of the block
package sic_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int PROD_W    = 66;
  localparam int DET_W     = 67;
  localparam int MAG_W     = 66;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int MARGIN_W  = 24;
  localparam int T_OUT_W   = 25;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_T_MARGIN   = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] d_x;
    logic signed [COORD_W-1:0] d_y;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [T_OUT_W-1:0]        t_first;
    logic [T_OUT_W-1:0]        t_second;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } res_t;

  // classified request handed from front to back
  typedef struct packed {
    status_t                   status;
    logic                      eq0;
    logic                      eq1;
    logic [MAG_W-1:0]          n0_mag;
    logic [MAG_W-1:0]          n1_mag;
    logic [MAG_W-1:0]          den_mag;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [DIFF_W-1:0]  u_x;
    logic signed [DIFF_W-1:0]  u_y;
  } job_t;

  function automatic logic [MAG_W-1:0] det_mag(logic signed [DET_W-1:0] x);
    logic signed [DET_W-1:0] n;
    n = (x < 0) ? -x : x;
    return n[MAG_W-1:0];
  endfunction

endpackage

// ----- src/sic_front.sv -----
// front end: differences, exact products, determinants and classification
// depends on sic_pkg
module sic_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc_i,
  input  sic_pkg::req_t                 req_i,
  input  logic [sic_pkg::CFG_W-1:0]     min_len_sq_i,
  output logic                          push_o,
  output sic_pkg::job_t                 job_o
);
  import sic_pkg::*;

  logic [3:0] vld_r;

  // stage 1: differences
  logic signed [DIFF_W-1:0] ux1_r, uy1_r, vx1_r, vy1_r, wx1_r, wy1_r;
  logic signed [COORD_W-1:0] ax1_r, ay1_r;
  // stage 2: products
  logic signed [PROD_W-1:0] uxx_r, uyy_r, vxx_r, vyy_r;
  logic signed [PROD_W-1:0] uyvx_r, uxvy_r, vxwy_r, vywx_r, uxwy_r, uywx_r;
  logic signed [DIFF_W-1:0] ux2_r, uy2_r;
  logic signed [COORD_W-1:0] ax2_r, ay2_r;
  // stage 3: sums and determinants
  logic signed [DET_W-1:0] su_r, sv_r, den_r, n0_r, n1_r;
  logic signed [DIFF_W-1:0] ux3_r, uy3_r;
  logic signed [COORD_W-1:0] ax3_r, ay3_r;
  // stage 4: floor check, magnitudes and signs
  logic short_r, den_zero_r, den_neg_r, n0_neg_r, n1_neg_r;
  logic [MAG_W-1:0] den_mag_r, n0_mag_r, n1_mag_r;
  logic signed [DIFF_W-1:0] ux4_r, uy4_r;
  logic signed [COORD_W-1:0] ax4_r, ay4_r;

  logic signed [DET_W-1:0] floor_s;
  logic ok0, ok1;

  assign floor_s = $signed({{(DET_W-CFG_W){1'b0}}, min_len_sq_i});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], acc_i};
    end
  end

  always_ff @(posedge clk) begin
    ux1_r <= DIFF_W'(req_i.b_x) - DIFF_W'(req_i.a_x);
    uy1_r <= DIFF_W'(req_i.b_y) - DIFF_W'(req_i.a_y);
    vx1_r <= DIFF_W'(req_i.d_x) - DIFF_W'(req_i.c_x);
    vy1_r <= DIFF_W'(req_i.d_y) - DIFF_W'(req_i.c_y);
    wx1_r <= DIFF_W'(req_i.c_x) - DIFF_W'(req_i.a_x);
    wy1_r <= DIFF_W'(req_i.c_y) - DIFF_W'(req_i.a_y);
    ax1_r <= req_i.a_x;
    ay1_r <= req_i.a_y;

    uxx_r  <= ux1_r * ux1_r;
    uyy_r  <= uy1_r * uy1_r;
    vxx_r  <= vx1_r * vx1_r;
    vyy_r  <= vy1_r * vy1_r;
    uyvx_r <= uy1_r * vx1_r;
    uxvy_r <= ux1_r * vy1_r;
    vxwy_r <= vx1_r * wy1_r;
    vywx_r <= vy1_r * wx1_r;
    uxwy_r <= ux1_r * wy1_r;
    uywx_r <= uy1_r * wx1_r;
    ux2_r <= ux1_r;
    uy2_r <= uy1_r;
    ax2_r <= ax1_r;
    ay2_r <= ay1_r;

    su_r  <= DET_W'(uxx_r) + DET_W'(uyy_r);
    sv_r  <= DET_W'(vxx_r) + DET_W'(vyy_r);
    den_r <= DET_W'(uyvx_r) - DET_W'(uxvy_r);
    n0_r  <= DET_W'(vxwy_r) - DET_W'(vywx_r);
    n1_r  <= DET_W'(uxwy_r) - DET_W'(uywx_r);
    ux3_r <= ux2_r;
    uy3_r <= uy2_r;
    ax3_r <= ax2_r;
    ay3_r <= ay2_r;

    short_r    <= (su_r < floor_s) || (sv_r < floor_s);
    den_zero_r <= (den_r == '0);
    den_neg_r  <= den_r[DET_W-1];
    n0_neg_r   <= n0_r[DET_W-1];
    n1_neg_r   <= n1_r[DET_W-1];
    den_mag_r  <= det_mag(den_r);
    n0_mag_r   <= det_mag(n0_r);
    n1_mag_r   <= det_mag(n1_r);
    ux4_r <= ux3_r;
    uy4_r <= uy3_r;
    ax4_r <= ax3_r;
    ay4_r <= ay3_r;
  end

  // parameter lies in [0, 1] when signs agree (or zero) and |n| <= |den|
  assign ok0 = ((n0_mag_r == '0) || (n0_neg_r == den_neg_r)) && (n0_mag_r <= den_mag_r);
  assign ok1 = ((n1_mag_r == '0) || (n1_neg_r == den_neg_r)) && (n1_mag_r <= den_mag_r);

  always_comb begin
    job_o.status = ST_HIT;
    priority if (short_r)       job_o.status = ST_DEGEN;
    else if (den_zero_r)        job_o.status = ST_PARALLEL;
    else if (!(ok0 && ok1))     job_o.status = ST_OUTSIDE;
    else                        job_o.status = ST_HIT;
    job_o.eq0     = (n0_mag_r == den_mag_r);
    job_o.eq1     = (n1_mag_r == den_mag_r);
    job_o.n0_mag  = n0_mag_r;
    job_o.n1_mag  = n1_mag_r;
    job_o.den_mag = den_mag_r;
    job_o.a_x     = ax4_r;
    job_o.a_y     = ay4_r;
    job_o.u_x     = ux4_r;
    job_o.u_y     = uy4_r;
  end

  // push is raised while stage 4 holds the request
  assign push_o = vld_r[3];

endmodule

// ----- src/sic_queue.sv -----
// two-entry request queue between front and back, registered read
// depends on sic_pkg
module sic_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  sic_pkg::job_t  job_i,
  output logic           valid_o,
  output sic_pkg::job_t  job_o,
  output logic           full_o
);
  import sic_pkg::*;

  job_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               pop;
  logic               valid_r;
  job_t               job_r;

  // the back end never stalls, so drain whenever anything is held
  assign pop = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (!push_i && pop) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push_i) mem[wr_ptr_r] <= job_i;
    if (pop) job_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (push_i) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      cnt_r   <= cnt_nxt;
      valid_r <= pop;
    end
  end

  assign valid_o = valid_r;
  assign job_o   = job_r;
  assign full_o  = (cnt_r == Q_CNT_W'(Q_DEPTH));

endmodule

// ----- src/sic_back.sv -----
// back end: two pipelined restoring dividers, margin test, crossing point
// depends on sic_pkg
module sic_back #(
  parameter int T_FRAC_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  input  sic_pkg::job_t                  job_i,
  input  logic [sic_pkg::MARGIN_W-1:0]   margin_i,
  output logic                           valid_o,
  output sic_pkg::res_t                  res_o
);
  import sic_pkg::*;

  localparam int QW = T_FRAC_BITS + 1;
  localparam int CW = QW + MARGIN_W + 1;
  localparam int PW = QW + 1 + DIFF_W;

  typedef struct packed {
    status_t                   status;
    logic                      eq0;
    logic                      eq1;
    logic [MAG_W-1:0]          r0;
    logic [MAG_W-1:0]          r1;
    logic [MAG_W-1:0]          d;
    logic [T_FRAC_BITS-1:0]    q0;
    logic [T_FRAC_BITS-1:0]    q1;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [DIFF_W-1:0]  u_x;
    logic signed [DIFF_W-1:0]  u_y;
  } stg_t;

  logic [T_FRAC_BITS:0] vld_r;
  stg_t                 stg_r [T_FRAC_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[T_FRAC_BITS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0].status <= job_i.status;
    stg_r[0].eq0    <= job_i.eq0;
    stg_r[0].eq1    <= job_i.eq1;
    stg_r[0].r0     <= job_i.n0_mag;
    stg_r[0].r1     <= job_i.n1_mag;
    stg_r[0].d      <= job_i.den_mag;
    stg_r[0].q0     <= '0;
    stg_r[0].q1     <= '0;
    stg_r[0].a_x    <= job_i.a_x;
    stg_r[0].a_y    <= job_i.a_y;
    stg_r[0].u_x    <= job_i.u_x;
    stg_r[0].u_y    <= job_i.u_y;
  end

  // one quotient bit per stage for each parameter
  for (genvar k = 1; k <= T_FRAC_BITS; k++) begin : g_div
    logic [MAG_W:0] sh0, sh1, dd;
    logic           ge0, ge1;
    stg_t           nxt;

    assign sh0 = {stg_r[k-1].r0, 1'b0};
    assign sh1 = {stg_r[k-1].r1, 1'b0};
    assign dd  = {1'b0, stg_r[k-1].d};
    assign ge0 = (sh0 >= dd);
    assign ge1 = (sh1 >= dd);

    always_comb begin
      nxt    = stg_r[k-1];
      nxt.r0 = ge0 ? MAG_W'(sh0 - dd) : MAG_W'(sh0);
      nxt.r1 = ge1 ? MAG_W'(sh1 - dd) : MAG_W'(sh1);
      nxt.q0 = {stg_r[k-1].q0[T_FRAC_BITS-2:0], ge0};
      nxt.q1 = {stg_r[k-1].q1[T_FRAC_BITS-2:0], ge1};
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= nxt;
    end
  end

  // finishing stage: exact-one case, margin window, offset products
  stg_t              last;
  logic [QW-1:0]     q0w, q1w;
  logic [CW-1:0]     one_c, mar_c;
  logic              in0, in1, hit;
  status_t           status_nxt;

  logic              f_vld_r, f_hit_r;
  status_t           f_status_r;
  logic [QW-1:0]     f_q0_r, f_q1_r;
  logic signed [PW-1:0] f_px_r, f_py_r;
  logic signed [COORD_W-1:0] f_ax_r, f_ay_r;

  logic              out_vld_r;
  res_t              res_r;
  logic signed [PW-1:0] offx, offy;

  assign last  = stg_r[T_FRAC_BITS];
  assign q0w   = last.eq0 ? (QW'(1) << T_FRAC_BITS) : {1'b0, last.q0};
  assign q1w   = last.eq1 ? (QW'(1) << T_FRAC_BITS) : {1'b0, last.q1};
  assign one_c = CW'(1) << T_FRAC_BITS;
  assign mar_c = CW'(margin_i);
  assign in0   = (CW'(q0w) >= mar_c) && (CW'(q0w) + mar_c <= one_c);
  assign in1   = (CW'(q1w) >= mar_c) && (CW'(q1w) + mar_c <= one_c);
  assign hit   = (last.status == ST_HIT) && in0 && in1;
  assign status_nxt = (last.status == ST_HIT && !hit) ? ST_OUTSIDE : last.status;

  always_ff @(posedge clk) begin
    f_hit_r    <= hit;
    f_status_r <= status_nxt;
    f_q0_r     <= q0w;
    f_q1_r     <= q1w;
    f_px_r     <= $signed({1'b0, q0w}) * last.u_x;
    f_py_r     <= $signed({1'b0, q0w}) * last.u_y;
    f_ax_r     <= last.a_x;
    f_ay_r     <= last.a_y;
  end

  // arithmetic shift floors the signed offset
  assign offx = f_px_r >>> T_FRAC_BITS;
  assign offy = f_py_r >>> T_FRAC_BITS;

  always_ff @(posedge clk) begin
    res_r.status <= f_status_r;
    if (f_hit_r) begin
      res_r.t_first  <= T_OUT_W'(f_q0_r);
      res_r.t_second <= T_OUT_W'(f_q1_r);
      res_r.cross_x  <= f_ax_r + offx[COORD_W-1:0];
      res_r.cross_y  <= f_ay_r + offy[COORD_W-1:0];
    end else begin
      res_r.t_first  <= '0;
      res_r.t_second <= '0;
      res_r.cross_x  <= '0;
      res_r.cross_y  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      f_vld_r   <= vld_r[T_FRAC_BITS];
      out_vld_r <= f_vld_r;
    end
  end

  assign valid_o = out_vld_r;
  assign res_o   = res_r;

endmodule

// ----- src/segment_intersection_core.sv -----
// top level of the 2d segment intersection core
// depends on sic_pkg, sic_front, sic_queue, sic_back
//
// Takes one request (segments AB and CD, signed Q16.16) per clock and returns
// one result per request, in order, as a single-cycle out_valid strobe; the
// receiver cannot stall. A request is taken when start is high and busy is low.
// The pipeline holds four front register stages
// (differences, exact 66-bit products, determinants, magnitudes with the
// classification), the two registers of the queue (write and registered read),
// the divider input stage, one stage per quotient bit in each of the two
// pipelined restoring dividers, a finishing stage and the output register.
// Throughput is one request per cycle; the divider pipeline sets the depth.
// Configuration writes take effect at once and belong in idle periods.
module segment_intersection_core #(
  parameter int T_FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  sic_pkg::req_t                     in_req,
  // result channel
  output logic                              out_valid,
  output sic_pkg::res_t                     out_res,
  // configuration port
  input  logic                              cfg_we,
  input  logic [sic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sic_pkg::CFG_W-1:0]         cfg_data
);
  import sic_pkg::*;

  logic [CFG_W-1:0]    min_len_sq_r;
  logic [MARGIN_W-1:0] t_margin_r;

  logic  accept;
  logic  push;
  job_t  job_front;
  logic  q_valid;
  job_t  job_q;
  logic  q_full;

  // register file, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_sq_r <= CFG_W'(4295);
      t_margin_r   <= MARGIN_W'(17);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LEN_SQ: min_len_sq_r <= cfg_data;
        REG_T_MARGIN:   t_margin_r   <= cfg_data[MARGIN_W-1:0];
        default:        min_len_sq_r <= min_len_sq_r;
      endcase
    end
  end

  // the back end drains every cycle, so the queue only fills on a fault
  assign busy   = q_full;
  assign accept = start && !busy;

  // front: differences, products, determinants and early status
  sic_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_i        (accept),
    .req_i        (in_req),
    .min_len_sq_i (min_len_sq_r),
    .push_o       (push),
    .job_o        (job_front)
  );

  // decoupling queue
  sic_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .job_i   (job_front),
    .valid_o (q_valid),
    .job_o   (job_q),
    .full_o  (q_full)
  );

  // back: quotients, margin window and crossing point
  sic_back #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (q_valid),
    .job_i    (job_q),
    .margin_i (t_margin_r),
    .valid_o  (out_valid),
    .res_o    (out_res)
  );

endmodule

// ----- src/sic_checker.sv -----
// port-level checks for the segment intersection core, bound to the top
// depends on sic_pkg and segment_intersection_core
module sic_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input sic_pkg::req_t                 in_req,
  input logic                          out_valid,
  input sic_pkg::res_t                 out_res,
  input logic                          cfg_we,
  input logic [sic_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [sic_pkg::CFG_W-1:0]     cfg_data
);
  import sic_pkg::*;

  // request-to-result edge distance at the default parameter width
  localparam int PIPE_DEPTH = 33;

  // a miss carries no parameters and no point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_HIT |->
      out_res.t_first == '0 && out_res.t_second == '0 &&
      out_res.cross_x == '0 && out_res.cross_y == '0)
    else $error("miss result with nonzero payload");

  // reset flushes the result strobe
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // back end drains every cycle, so requests are never refused
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result strobe traces back to a request one pipe depth earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without request");

endmodule

bind segment_intersection_core sic_checker u_sic_checker (.*);

// ----- verif/segment_intersection_checker.sv -----
// checker for the segment intersection core: predicts each result and compares
// depends on sic_pkg; instantiated beside the block by segment_intersection_core_tb
module segment_intersection_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  sic_pkg::req_t  in_req,
  input  logic           out_valid,
  input  sic_pkg::res_t  out_res,
  input  logic           cfg_we,
  input  logic [sic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sic_pkg::CFG_W-1:0]     cfg_data,
  output int             fail_count,
  output int             pending_count
);
  import sic_pkg::*;

  localparam int TQ = 24;

  logic [31:0] floor_len_sq;
  logic [23:0] end_margin;
  res_t        expected_results[$];

  assign pending_count = expected_results.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // exact quotient floor(|n| * 2^TQ / |d|), valid only when signs agree (or n is 0) and |n| <= |d|
  function automatic bit frac_of(input logic signed [69:0] n,
                                 input logic signed [69:0] d,
                                 output logic [24:0] q);
    logic [69:0] nm, dm;
    logic [99:0] wide;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    q = '0;
    if (nm != 0 && ((n < 0) != (d < 0))) return 0;
    if (nm > dm) return 0;
    wide = {30'b0, nm} << TQ;
    q = 25'(wide / {30'b0, dm});
    return 1;
  endfunction

  function automatic bit margin_ok(input logic [24:0] q);
    return q >= end_margin && ({1'b0, q} + end_margin) <= (26'd1 << TQ);
  endfunction

  function automatic logic [31:0] point_along(input logic signed [33:0] a,
                                              input logic signed [33:0] u,
                                              input logic [24:0] q);
    logic signed [63:0] prod;
    prod = $signed({1'b0, q}) * u;
    return 32'(64'(a) + (prod >>> TQ));  // arithmetic shift floors, as required
  endfunction

  function automatic res_t predict_crossing(input req_t r);
    res_t o;
    logic signed [33:0] ux, uy, vx, vy, wx, wy;
    logic signed [69:0] den, n0, n1;
    logic [69:0] lu, lv;
    logic [24:0] q0, q1;
    bit ok0, ok1;
    o = '0;
    ux = 34'(r.b_x) - 34'(r.a_x); uy = 34'(r.b_y) - 34'(r.a_y);
    vx = 34'(r.d_x) - 34'(r.c_x); vy = 34'(r.d_y) - 34'(r.c_y);
    wx = 34'(r.c_x) - 34'(r.a_x); wy = 34'(r.c_y) - 34'(r.a_y);
    lu = 70'(ux) * 70'(ux) + 70'(uy) * 70'(uy);
    lv = 70'(vx) * 70'(vx) + 70'(vy) * 70'(vy);
    if (lu < floor_len_sq || lv < floor_len_sq) begin
      o.status = ST_DEGEN;
      return o;
    end
    den = 70'(uy) * 70'(vx) - 70'(ux) * 70'(vy);
    if (den == 0) begin
      o.status = ST_PARALLEL;
      return o;
    end
    n0 = 70'(vx) * 70'(wy) - 70'(vy) * 70'(wx);
    n1 = 70'(ux) * 70'(wy) - 70'(uy) * 70'(wx);
    ok0 = frac_of(n0, den, q0);
    ok1 = frac_of(n1, den, q1);
    if (!ok0 || !ok1 || !margin_ok(q0) || !margin_ok(q1)) begin
      o.status = ST_OUTSIDE;
      return o;
    end
    o.status = ST_HIT;
    o.t_first = q0;
    o.t_second = q1;
    o.cross_x = point_along(34'(r.a_x), ux, q0);
    o.cross_y = point_along(34'(r.a_y), uy, q0);
    return o;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      floor_len_sq <= 32'd4295;
      end_margin <= 24'd17;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_LEN_SQ) floor_len_sq <= cfg_data;
        else end_margin <= cfg_data[23:0];
      end
      if (start && !busy) expected_results.push_back(predict_crossing(in_req));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_res.status), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_res.status !== want.status)
            report_mismatch("status", 64'(out_res.status), 64'(want.status));
          if (out_res.t_first !== want.t_first)
            report_mismatch("t_first", 64'(out_res.t_first), 64'(want.t_first));
          if (out_res.t_second !== want.t_second)
            report_mismatch("t_second", 64'(out_res.t_second), 64'(want.t_second));
          if (out_res.cross_x !== want.cross_x)
            report_mismatch("cross_x", 64'(unsigned'(out_res.cross_x)),
                            64'(unsigned'(want.cross_x)));
          if (out_res.cross_y !== want.cross_y)
            report_mismatch("cross_y", 64'(unsigned'(out_res.cross_y)),
                            64'(unsigned'(want.cross_y)));
        end
      end
    end
  end
endmodule

// ----- verif/segment_intersection_core_tb.sv -----
// testbench top for the segment intersection core: stimulus and verdict
// depends on sic_pkg, segment_intersection_core and segment_intersection_checker
module segment_intersection_core_tb;
  import sic_pkg::*;

  localparam int LATENCY = 24 + 9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  res_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count;
  int pending_count;
  int idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersection_core uut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .cfg_we, .cfg_index, .cfg_data
  );

  segment_intersection_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending_count
  );

  // hang guard: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("segment_intersection_core_tb: errors");
    $finish;
  end

  // present one request, with an optional random gap first; start stays high
  // across back-to-back requests so it is never dropped and raised in one step
  task automatic send_request(input req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one write, then cfg_we is dropped before returning, so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t seg_pair(input int ax, ay, bx, by, cx, cy, dx, dy);
    req_t r;
    r.a_x = ax; r.a_y = ay; r.b_x = bx; r.b_y = by;
    r.c_x = cx; r.c_y = cy; r.d_x = dx; r.d_y = dy;
    return r;
  endfunction

  // scaled coordinate: random magnitude class so small and full-range both occur
  function automatic logic [31:0] rand_coord;
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      2: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(7)
                                        : 32'h8000_0000 + $urandom_range(7);
    endcase
  endfunction

  // mostly crossing segments: build around a shared point, then perturb
  function automatic req_t rand_request;
    req_t r;
    int px, py, s;
    logic [31:0] k;
    if ($urandom_range(99) < 65) begin
      s = $urandom_range(0, 3) == 0 ? 24 : $urandom_range(4, 18);
      px = $signed($urandom) >>> 2;
      py = $signed($urandom) >>> 2;
      k = $urandom;
      r.a_x = px - ($signed($urandom) >>> (31 - s));
      r.a_y = py - ($signed($urandom) >>> (31 - s));
      r.b_x = px + (px - r.a_x) * ($urandom_range(1, 3));
      r.b_y = py + (py - r.a_y) * ($urandom_range(1, 3));
      r.c_x = px - ($signed($urandom) >>> (31 - s));
      r.c_y = py - ($signed($urandom) >>> (31 - s));
      r.d_x = px + (px - r.c_x);
      r.d_y = py + (py - r.c_y);
      if (k[0]) r.d_x = r.d_x + $signed(k[8:1]) - 128;
      if (k[9] && k[10]) begin
        // parallel copy of AB
        r.c_x = r.a_x + $urandom_range(1, 100); r.c_y = r.a_y;
        r.d_x = r.b_x + (r.c_x - r.a_x); r.d_y = r.b_y;
      end
    end else begin
      r.a_x = rand_coord(); r.a_y = rand_coord(); r.b_x = rand_coord();
      r.b_y = rand_coord(); r.c_x = rand_coord(); r.c_y = rand_coord();
      r.d_x = rand_coord(); r.d_y = rand_coord();
      if ($urandom_range(9) == 0) begin
        r.b_x = r.a_x + $urandom_range(1);  // near-zero length
        r.b_y = r.a_y;
      end
    end
    return r;
  endfunction

  task automatic random_phase(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_request(rand_request());
  endtask

  localparam int ONE = 32'h0001_0000;

  initial begin
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clean hit, end points, parallel, collinear, degenerate, outside
    send_request(seg_pair(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
    send_request(seg_pair(0, 0, 4*ONE, 0, 4*ONE, -ONE, 4*ONE, ONE));
    send_request(seg_pair(0, 0, 4*ONE, 0, 0, -ONE, 0, ONE));
    send_request(seg_pair(0, 0, 4*ONE, 0, 0, ONE, 4*ONE, ONE));
    send_request(seg_pair(0, 0, 4*ONE, 0, ONE, 0, 6*ONE, 0));
    send_request(seg_pair(5, 5, 5, 5, 0, 0, ONE, ONE));
    send_request(seg_pair(0, 0, 64, 0, 0, -ONE, ONE, ONE));
    send_request(seg_pair(0, 0, ONE, 0, 3*ONE, -ONE, 3*ONE, ONE));
    send_request(seg_pair(0, 0, -ONE, 0, -ONE/2, ONE, -ONE/2, -ONE));
    send_request(seg_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    send_request(seg_pair(32'h7fff_ffff, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff,
                          0, 32'h8000_0000));
    send_request(seg_pair(0, 0, 3, 7, 1, 5, 2, -9));
    send_request(seg_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_request(seg_pair(0, 0, 3*ONE, ONE, 0, ONE, 3*ONE, 0));
    drain();

    // zero margin and zero floor: end points now hit, tiny segments accepted
    write_reg(REG_T_MARGIN, 32'd0);
    write_reg(REG_MIN_LEN_SQ, 32'd0);
    send_request(seg_pair(0, 0, 4*ONE, 0, 4*ONE, -ONE, 4*ONE, ONE));
    send_request(seg_pair(0, 0, 4*ONE, 0, 0, -ONE, 0, ONE));
    send_request(seg_pair(0, 0, 2, 2, 0, 2, 2, 0));
    send_request(seg_pair(5, 5, 5, 5, 0, 0, ONE, ONE));
    random_phase(150, 0);
    drain();

    // widest floor and a margin just past one half: nothing can hit
    write_reg(REG_MIN_LEN_SQ, 32'hffff_ffff);
    write_reg(REG_T_MARGIN, 32'h80_0001);
    send_request(seg_pair(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
    random_phase(100, 65);
    drain();

    // margin of exactly one half: only the exact midpoints hit
    write_reg(REG_MIN_LEN_SQ, 32'd1);
    write_reg(REG_T_MARGIN, 32'h80_0000);
    send_request(seg_pair(0, 0, 2*ONE, 2*ONE, 0, 2*ONE, 2*ONE, 0));
    random_phase(100, 17);
    drain();

    // defaults again, random registers afterward
    write_reg(REG_MIN_LEN_SQ, 32'd4295);
    write_reg(REG_T_MARGIN, 32'd17);
    random_phase(200, 0);
    drain();
    write_reg(REG_MIN_LEN_SQ, $urandom);
    write_reg(REG_T_MARGIN, {8'h0, 24'($urandom_range(0, 32'h10_0000))});
    random_phase(200, 65);
    drain();

    if (fail_count == 0) begin
      $display("segment_intersection_core_tb: clean");
    end else begin
      $display("segment_intersection_core_tb: errors");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/sic_pkg.sv
src/sic_front.sv
src/sic_queue.sv
src/sic_back.sv
src/segment_intersection_core.sv
src/sic_checker.sv
verif/segment_intersection_checker.sv
verif/segment_intersection_core_tb.sv
